>>> design/tzic_pkg.sv
package tzic_pkg;

  // Tank machine states, coded as reported on the result port.
  typedef enum logic [3:0] {
    M_UNKNOWN     = 4'd0,
    M_OFF         = 4'd1,
    M_DRAIN_ON    = 4'd2,
    M_DRAINING    = 4'd3,
    M_DRAIN_EMPTY = 4'd4,
    M_FILLING     = 4'd5,
    M_FULL        = 4'd6,
    M_FILL_FAULT  = 4'd7,
    M_DRAIN_FAULT = 4'd8
  } tank_mode_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_TOTAL,
    S_TANK,
    S_ZONES,
    S_SCAN,
    S_SERVE_A,
    S_SERVE_B,
    S_CHECK,
    S_END,
    S_OUT
  } seq_state_t;

  // What a finished zone search hands control to.
  typedef enum logic [1:0] {
    TAG_SERVE,
    TAG_RECHECK,
    TAG_RUN
  } scan_tag_t;

  // Item function codes.
  localparam logic [3:0] F_POLL      = 4'd0;
  localparam logic [3:0] F_ZONE_ON   = 4'd1;
  localparam logic [3:0] F_ZONE_OFF  = 4'd2;
  localparam logic [3:0] F_ZONE_RST  = 4'd3;
  localparam logic [3:0] F_ZONE_TGT  = 4'd4;
  localparam logic [3:0] F_ZONE_CNT  = 4'd5;
  localparam logic [3:0] F_RUN       = 4'd6;
  localparam logic [3:0] F_STOP      = 4'd7;
  localparam logic [3:0] F_RESET_ALL = 4'd8;
  localparam logic [3:0] F_SET_TOTAL = 4'd9;
  localparam logic [3:0] F_TEMP      = 4'd10;

  // Configuration register indexes.
  localparam logic [2:0] R_DRAIN_ON_TIME  = 3'd0;
  localparam logic [2:0] R_DRAIN_MAX_TIME = 3'd1;
  localparam logic [2:0] R_FILL_MAX_TIME  = 3'd2;
  localparam logic [2:0] R_FLOW_TICK_MS   = 3'd3;
  localparam logic [2:0] R_FITTED_MASK    = 3'd4;

  // Fitted mask bit positions.
  localparam int FIT_WMAX  = 0;
  localparam int FIT_WMIN  = 1;
  localparam int FIT_FBD   = 2;
  localparam int FIT_FBP   = 3;
  localparam int FIT_METER = 4;
  localparam int FIT_FILL  = 5;
  localparam int FIT_DRAIN = 6;
  localparam int FIT_PUMP  = 7;

  // Drive bit positions.
  localparam int D_FILL  = 0;
  localparam int D_DRAIN = 1;
  localparam int D_PUMP  = 2;

  localparam logic [3:0] NO_ZONE = 4'd8;

  // Operands of the shared subtract-and-compare unit.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] limit;
  } alu_req_t;

  // Write request into the zone table.
  typedef struct packed {
    logic        goal_we;
    logic        deliv_we;
    logic        clr_all;
    logic [4:0]  idx;
    logic [31:0] data;
  } tbl_wr_t;

endpackage

>>> design/tzic_alu.sv
// Shared unit: (a - b) mod 2^32 compared against a limit.
module tzic_alu (
  input  tzic_pkg::alu_req_t req,
  output logic               ge
);
  logic [31:0] diff;

  assign diff = req.a - req.b;
  assign ge   = diff >= req.limit;
endmodule

>>> design/tzic_zone_table.sv
// Per-zone target and delivered counts, one write and one read address.
module tzic_zone_table #(
  parameter int ZONES      = 8,
  parameter int COUNT_BITS = 24,
  parameter int ZW         = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tzic_pkg::tbl_wr_t     wr,
  input  logic [ZW-1:0]         rd_idx,
  output logic [COUNT_BITS-1:0] rd_goal,
  output logic [COUNT_BITS-1:0] rd_deliv
);
  logic [COUNT_BITS-1:0] goal  [ZONES];
  logic [COUNT_BITS-1:0] deliv [ZONES];
  logic [ZW-1:0]         widx;

  assign widx = ZW'(wr.idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ZONES; i++) begin
        goal[i]  <= '0;
        deliv[i] <= '0;
      end
    end else begin
      if (wr.goal_we) begin
        goal[widx] <= COUNT_BITS'(wr.data);
      end
      if (wr.clr_all) begin
        for (int i = 0; i < ZONES; i++) begin
          deliv[i] <= '0;
        end
      end else if (wr.deliv_we) begin
        deliv[widx] <= COUNT_BITS'(wr.data);
      end
    end
  end

  assign rd_goal  = goal[rd_idx];
  assign rd_deliv = deliv[rd_idx];
endmodule

>>> design/tank_and_zone_irrigation_controller.sv
// Channel   Direction  Signals                          Content
// s_axis    in         s_tvalid s_tready s_tdata s_tuser  poll tick or command
// m_axis    out        m_tvalid m_tready m_tdata m_tuser  state after the item
// cfg       in         cfg_valid cfg_ready cfg_index cfg_data  register write
//
// One beat is processed at a time by a small sequencer around one shared
// subtract-and-compare unit. A poll runs up to three zone searches; each
// walks the table one entry per cycle and sets the length of a poll.
// Reset is synchronous and clears all state but the latched beat; the zone
// table clears at once.
// A finished result waits in the output register while the next beat is
// already accepted; the sequencer only holds if that register is still full.
module tank_and_zone_irrigation_controller #(
  parameter int ZONES      = 8,
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] zone, [26:3] value, [27] level_max, [28] level_min,
  // [29] drain_feedback, [30] pump_feedback, [31] flow_pulse, [63:32] now_ms
  input  logic [63:0] s_tdata,
  // [3:0] func
  input  logic [3:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] tank_state, [5:4] fault_code, [6] fill_valve, [7] drain_valve,
  // [8] pump_on, [16:9] zone_valves, [20:17] active_zone,
  // [44:21] active_count, [45] running, [69:46] total_count, [70] frozen,
  // [71] zero
  output logic [71:0] m_tdata,
  // [0] accepted
  output logic        m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int OUTZ = (ZONES < 8) ? ZONES : 8;
  localparam logic [31:0] CMAX = 32'((64'd1 << COUNT_BITS) - 64'd1);
  localparam logic [ZW-1:0] LAST = ZW'(ZONES - 1);

  // Configuration registers.
  logic [31:0] drain_on_time, drain_max_time, fill_max_time;
  logic [15:0] flow_tick_ms;
  logic [7:0]  fitted_mask;

  // Latched beat.
  logic [3:0]  func;
  logic [2:0]  zone;
  logic [23:0] value;
  logic        level_max, level_min, drain_feedback, pump_feedback, flow_pulse;
  logic [31:0] now_ms;

  // Controller state.
  tzic_pkg::seq_state_t state, state_next;
  tzic_pkg::scan_tag_t  scan_tag;
  tzic_pkg::tank_mode_t tank_mode;
  logic [31:0]           phase_start, flow_start;
  logic [2:0]            drive_bits;
  logic [1:0]            pulse_history;
  logic [ZONES-1:0]      zone_enabled, zone_busy;
  logic                  run_flag, freeze_flag;
  logic [COUNT_BITS-1:0] pulse_total;
  logic                  ok;
  logic [ZW-1:0]         zsel, scan_i, cand_i;
  logic                  cand_f, need_pump;
  logic [COUNT_BITS-1:0] goal_q, done_q;

  // Shared unit and table.
  tzic_pkg::alu_req_t    alu_req;
  logic                  alu_ge;
  tzic_pkg::tbl_wr_t     tbl_wr;
  logic [ZW-1:0]         rd_idx;
  logic [COUNT_BITS-1:0] rd_goal, rd_deliv;

  tzic_alu u_alu (
    .req (alu_req),
    .ge  (alu_ge)
  );

  tzic_zone_table #(
    .ZONES      (ZONES),
    .COUNT_BITS (COUNT_BITS),
    .ZW         (ZW)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr       (tbl_wr),
    .rd_idx   (rd_idx),
    .rd_goal  (rd_goal),
    .rd_deliv (rd_deliv)
  );

  // Sensor levels as seen through the fitted mask.
  logic wmax, wmin, fbd, fbp, meter, zone_ok;
  assign wmax    = fitted_mask[tzic_pkg::FIT_WMAX] & level_max;
  assign wmin    = fitted_mask[tzic_pkg::FIT_WMIN] & level_min;
  assign fbd     = fitted_mask[tzic_pkg::FIT_FBD] & drain_feedback;
  assign fbp     = fitted_mask[tzic_pkg::FIT_FBP] & pump_feedback;
  assign meter   = fitted_mask[tzic_pkg::FIT_METER];
  assign zone_ok = 32'(zone) < 32'(ZONES);

  function automatic logic [COUNT_BITS-1:0] clamp(input logic [23:0] v);
    logic [31:0] m;
    m = 32'(v[22:0]);
    if (v[23]) begin
      return '0;
    end else if (m > CMAX) begin
      return COUNT_BITS'(CMAX);
    end
    return COUNT_BITS'(m);
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    if (32'(v) >= CMAX) begin
      return v;
    end
    return v + 1'b1;
  endfunction

  // A drive bit only moves when its output is fitted.
  function automatic logic [2:0] set_drv(input logic [2:0] d, input int bit_pos,
                                         input logic on, input logic fit);
    logic [2:0] r;
    r = d;
    if (fit) begin
      r[bit_pos] = on;
    end
    return r;
  endfunction

  // Valve drives that go with entering a tank state.
  function automatic logic [2:0] move_drive(input tzic_pkg::tank_mode_t m,
                                            input logic [2:0] d,
                                            input logic [7:0] fit);
    logic [2:0] r;
    r = d;
    case (m)
      tzic_pkg::M_DRAIN_ON, tzic_pkg::M_DRAINING: begin
        r = set_drv(r, tzic_pkg::D_DRAIN, 1'b1, fit[tzic_pkg::FIT_DRAIN]);
        r = set_drv(r, tzic_pkg::D_FILL, 1'b0, fit[tzic_pkg::FIT_FILL]);
      end
      tzic_pkg::M_FILLING: begin
        r = set_drv(r, tzic_pkg::D_FILL, 1'b1, fit[tzic_pkg::FIT_FILL]);
      end
      tzic_pkg::M_DRAIN_EMPTY, tzic_pkg::M_FILL_FAULT: begin
        r = set_drv(r, tzic_pkg::D_FILL, 1'b0, fit[tzic_pkg::FIT_FILL]);
      end
      tzic_pkg::M_DRAIN_FAULT: begin
        r = set_drv(r, tzic_pkg::D_DRAIN, 1'b0, fit[tzic_pkg::FIT_DRAIN]);
      end
      default: begin
        r = set_drv(r, tzic_pkg::D_DRAIN, 1'b0, fit[tzic_pkg::FIT_DRAIN]);
        r = set_drv(r, tzic_pkg::D_FILL, 1'b0, fit[tzic_pkg::FIT_FILL]);
      end
    endcase
    return r;
  endfunction

  // Tank transition for a poll. The shared unit checks the timeout of the
  // current phase against the limit that belongs to it.
  tzic_pkg::tank_mode_t mode_tgt;
  logic                 mode_mv, mode_set, ps_set;
  logic [31:0]          lim_sel;

  always_comb begin
    case (tank_mode)
      tzic_pkg::M_DRAIN_ON: lim_sel = drain_on_time;
      tzic_pkg::M_DRAINING: lim_sel = drain_max_time;
      tzic_pkg::M_FILLING:  lim_sel = fill_max_time;
      default:              lim_sel = '0;
    endcase
  end

  always_comb begin
    mode_tgt = tank_mode;
    mode_mv  = 1'b0;
    mode_set = 1'b0;
    ps_set   = 1'b0;
    case (tank_mode)
      tzic_pkg::M_DRAIN_ON: begin
        if (fbd) begin
          ps_set = 1'b1; mode_mv = 1'b1; mode_tgt = tzic_pkg::M_DRAINING;
        end else if (alu_ge) begin
          mode_mv = 1'b1; mode_tgt = tzic_pkg::M_DRAIN_EMPTY;
        end
      end
      tzic_pkg::M_DRAINING: begin
        if (!fbd) begin
          mode_mv = 1'b1; mode_tgt = tzic_pkg::M_DRAIN_EMPTY;
        end else if (wmax) begin
          mode_mv = 1'b1; mode_tgt = tzic_pkg::M_FULL;
        end else if (alu_ge) begin
          mode_mv = 1'b1; mode_tgt = tzic_pkg::M_DRAIN_FAULT;
        end
      end
      tzic_pkg::M_DRAIN_EMPTY: begin
        if (wmax) begin
          mode_mv = 1'b1; mode_tgt = tzic_pkg::M_FULL;
        end else if (run_flag) begin
          ps_set = 1'b1; mode_mv = 1'b1; mode_tgt = tzic_pkg::M_FILLING;
        end
      end
      tzic_pkg::M_FILLING: begin
        if (fbd) begin
          ps_set = 1'b1; mode_mv = 1'b1; mode_tgt = tzic_pkg::M_DRAINING;
        end else if (wmax) begin
          mode_mv = 1'b1; mode_tgt = tzic_pkg::M_FULL;
        end else if (alu_ge) begin
          mode_mv = 1'b1; mode_tgt = tzic_pkg::M_FILL_FAULT;
        end
      end
      tzic_pkg::M_FULL: begin
        if (!wmax) begin
          ps_set = 1'b1; mode_mv = 1'b1; mode_tgt = tzic_pkg::M_DRAIN_ON;
        end
      end
      tzic_pkg::M_FILL_FAULT, tzic_pkg::M_DRAIN_FAULT: begin
        if (wmax) begin
          mode_mv = 1'b1; mode_tgt = tzic_pkg::M_FULL;
        end
      end
      default: begin
        // Unknown or off: a full tank is taken as is, without touching valves.
        if (wmax) begin
          mode_set = 1'b1; mode_tgt = tzic_pkg::M_FULL;
        end else begin
          ps_set = 1'b1; mode_mv = 1'b1; mode_tgt = tzic_pkg::M_DRAIN_ON;
        end
      end
    endcase
  end

  // Zone search step: the entry at scan_i may be busy, which ends the
  // search at once, or a candidate that still has work to do.
  logic        sc_busy, sc_cand, sc_done, sc_found;
  logic [ZW-1:0] sc_idx;
  assign sc_busy = zone_busy[scan_i];
  assign sc_cand = zone_enabled[scan_i] & ((rd_goal == '0) | ~alu_ge);
  assign sc_done = sc_busy | (scan_i == LAST);

  always_comb begin
    if (sc_busy) begin
      sc_found = 1'b1; sc_idx = scan_i;
    end else if (cand_f) begin
      sc_found = 1'b1; sc_idx = cand_i;
    end else begin
      sc_found = sc_cand; sc_idx = scan_i;
    end
  end

  logic tank_ready;
  assign tank_ready = (tank_mode == tzic_pkg::M_FULL) | wmax | wmin | fbp;

  // Result fields: lowest busy zone among those that have a valve bit.
  logic [3:0] act;
  logic [7:0] valves;
  always_comb begin
    act    = tzic_pkg::NO_ZONE;
    valves = '0;
    for (int i = OUTZ - 1; i >= 0; i--) begin
      valves[i] = zone_busy[i];
      if (zone_busy[i]) begin
        act = 4'(i);
      end
    end
  end

  logic out_free;
  assign out_free = ~m_tvalid | m_tready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tzic_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser == tzic_pkg::F_POLL) ? tzic_pkg::S_TOTAL
                                                     : tzic_pkg::S_CMD;
        end
      end
      tzic_pkg::S_CMD:   state_next = tzic_pkg::S_OUT;
      tzic_pkg::S_TOTAL: state_next = freeze_flag ? tzic_pkg::S_OUT : tzic_pkg::S_TANK;
      tzic_pkg::S_TANK:  state_next = tzic_pkg::S_ZONES;
      tzic_pkg::S_ZONES: begin
        if (!run_flag) begin
          state_next = tzic_pkg::S_END;
        end else if (!tank_ready) begin
          state_next = tzic_pkg::S_OUT;
        end else begin
          state_next = tzic_pkg::S_SCAN;
        end
      end
      tzic_pkg::S_SCAN: begin
        if (sc_done) begin
          case (scan_tag)
            tzic_pkg::TAG_SERVE:
              state_next = sc_found ? tzic_pkg::S_SERVE_A : tzic_pkg::S_END;
            tzic_pkg::TAG_RECHECK: state_next = tzic_pkg::S_END;
            default:               state_next = tzic_pkg::S_OUT;
          endcase
        end
      end
      tzic_pkg::S_SERVE_A: state_next = tzic_pkg::S_SERVE_B;
      tzic_pkg::S_SERVE_B: state_next = tzic_pkg::S_CHECK;
      tzic_pkg::S_CHECK: begin
        state_next = ((goal_q != '0) && alu_ge) ? tzic_pkg::S_SCAN : tzic_pkg::S_END;
      end
      tzic_pkg::S_END: begin
        state_next = (!need_pump && run_flag) ? tzic_pkg::S_SCAN : tzic_pkg::S_OUT;
      end
      tzic_pkg::S_OUT: begin
        if (out_free) begin
          state_next = tzic_pkg::S_IDLE;
        end
      end
      default: state_next = tzic_pkg::S_IDLE;
    endcase
  end

  // Control outputs: handshakes, shared unit operands, table access.
  always_comb begin
    s_tready = (state == tzic_pkg::S_IDLE);
    cfg_ready = 1'b1;
    alu_req  = '0;
    tbl_wr   = '0;
    tbl_wr.idx = 5'(zsel);
    rd_idx   = zsel;
    case (state)
      tzic_pkg::S_CMD: begin
        tbl_wr.idx = 5'(zone);
        if (zone_ok) begin
          case (func)
            tzic_pkg::F_ZONE_RST: tbl_wr.deliv_we = 1'b1;
            tzic_pkg::F_ZONE_TGT: begin
              tbl_wr.goal_we = 1'b1;
              tbl_wr.data    = 32'(clamp(value));
            end
            tzic_pkg::F_ZONE_CNT: begin
              tbl_wr.deliv_we = 1'b1;
              tbl_wr.data     = 32'(clamp(value));
            end
            default: ;
          endcase
        end
        if (func == tzic_pkg::F_RESET_ALL) begin
          tbl_wr.clr_all = 1'b1;
        end
      end
      tzic_pkg::S_TANK: begin
        alu_req.a = now_ms; alu_req.b = phase_start; alu_req.limit = lim_sel;
      end
      tzic_pkg::S_SCAN: begin
        rd_idx = scan_i;
        alu_req.a = 32'(rd_deliv); alu_req.limit = 32'(rd_goal);
      end
      tzic_pkg::S_SERVE_B: begin
        alu_req.a = now_ms; alu_req.b = flow_start; alu_req.limit = 32'(flow_tick_ms);
        tbl_wr.data = 32'(sat_inc(done_q));
        if (meter) begin
          tbl_wr.deliv_we = flow_pulse & ~pulse_history[0];
        end else begin
          tbl_wr.deliv_we = alu_ge;
        end
      end
      tzic_pkg::S_CHECK: begin
        alu_req.a = 32'(done_q); alu_req.limit = 32'(goal_q);
      end
      tzic_pkg::S_OUT: begin
        rd_idx = ZW'(act[2:0]);
      end
      default: ;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      drain_on_time  <= 32'd10000;
      drain_max_time <= 32'd600000;
      fill_max_time  <= 32'd600000;
      flow_tick_ms   <= 16'd1000;
      fitted_mask    <= 8'hFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tzic_pkg::R_DRAIN_ON_TIME:  drain_on_time  <= cfg_data;
        tzic_pkg::R_DRAIN_MAX_TIME: drain_max_time <= cfg_data;
        tzic_pkg::R_FILL_MAX_TIME:  fill_max_time  <= cfg_data;
        tzic_pkg::R_FLOW_TICK_MS:   flow_tick_ms   <= cfg_data[15:0];
        tzic_pkg::R_FITTED_MASK:    fitted_mask    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Beat capture; payload needs no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func           <= s_tuser;
      zone           <= s_tdata[2:0];
      value          <= s_tdata[26:3];
      level_max      <= s_tdata[27];
      level_min      <= s_tdata[28];
      drain_feedback <= s_tdata[29];
      pump_feedback  <= s_tdata[30];
      flow_pulse     <= s_tdata[31];
      now_ms         <= s_tdata[63:32];
    end
  end

  // Sequenced state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tzic_pkg::S_IDLE;
      scan_tag      <= tzic_pkg::TAG_SERVE;
      tank_mode     <= tzic_pkg::M_UNKNOWN;
      phase_start   <= '0;
      flow_start    <= '0;
      drive_bits    <= '0;
      pulse_history <= '0;
      zone_enabled  <= '0;
      zone_busy     <= '0;
      run_flag      <= 1'b0;
      freeze_flag   <= 1'b0;
      pulse_total   <= '0;
      ok            <= 1'b0;
      zsel          <= '0;
      scan_i        <= '0;
      cand_i        <= '0;
      cand_f        <= 1'b0;
      need_pump     <= 1'b0;
      goal_q        <= '0;
      done_q        <= '0;
      m_tvalid      <= 1'b0;
      m_tdata       <= '0;
      m_tuser       <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        tzic_pkg::S_IDLE: ok <= 1'b1;
        tzic_pkg::S_CMD: begin
          case (func)
            tzic_pkg::F_ZONE_ON: begin
              if (zone_ok) zone_enabled[ZW'(zone)] <= 1'b1;
              else ok <= 1'b0;
            end
            tzic_pkg::F_ZONE_OFF: begin
              if (zone_ok) begin
                zone_enabled[ZW'(zone)] <= 1'b0;
                zone_busy[ZW'(zone)]    <= 1'b0;
              end else begin
                ok <= 1'b0;
              end
            end
            tzic_pkg::F_ZONE_RST, tzic_pkg::F_ZONE_TGT, tzic_pkg::F_ZONE_CNT: begin
              if (!zone_ok) ok <= 1'b0;
            end
            tzic_pkg::F_RUN: run_flag <= 1'b1;
            tzic_pkg::F_STOP, tzic_pkg::F_RESET_ALL: begin
              zone_busy  <= '0;
              drive_bits <= set_drv(drive_bits, tzic_pkg::D_PUMP, 1'b0,
                                    fitted_mask[tzic_pkg::FIT_PUMP]);
              run_flag   <= 1'b0;
            end
            tzic_pkg::F_SET_TOTAL: pulse_total <= clamp(value);
            tzic_pkg::F_TEMP: begin
              if (value[23]) freeze_flag <= 1'b1;
            end
            default: ok <= 1'b0;
          endcase
        end
        tzic_pkg::S_TOTAL: begin
          // Total counting runs even while frozen.
          if (meter) begin
            if (flow_pulse && !pulse_history[1]) begin
              pulse_total <= sat_inc(pulse_total);
            end
            pulse_history[1] <= flow_pulse;
          end
          if (freeze_flag) begin
            logic [2:0] d;
            d = move_drive(tzic_pkg::M_OFF, drive_bits, fitted_mask);
            d[tzic_pkg::D_FILL]  = 1'b0;
            d[tzic_pkg::D_DRAIN] = 1'b0;
            drive_bits <= set_drv(d, tzic_pkg::D_PUMP, 1'b0,
                                  fitted_mask[tzic_pkg::FIT_PUMP]);
            tank_mode  <= tzic_pkg::M_OFF;
            zone_busy  <= '0;
          end
        end
        tzic_pkg::S_TANK: begin
          if (ps_set) phase_start <= now_ms;
          if (mode_mv || mode_set) tank_mode <= mode_tgt;
          if (mode_mv) drive_bits <= move_drive(mode_tgt, drive_bits, fitted_mask);
        end
        tzic_pkg::S_ZONES: begin
          scan_i    <= '0;
          cand_f    <= 1'b0;
          scan_tag  <= tzic_pkg::TAG_SERVE;
          need_pump <= 1'b0;
          if (run_flag && !tank_ready) begin
            zone_busy  <= '0;
            drive_bits <= set_drv(drive_bits, tzic_pkg::D_PUMP, 1'b0,
                                  fitted_mask[tzic_pkg::FIT_PUMP]);
          end
        end
        tzic_pkg::S_SCAN: begin
          if (sc_done) begin
            zsel <= sc_idx;
            case (scan_tag)
              tzic_pkg::TAG_RECHECK: need_pump <= sc_found;
              tzic_pkg::TAG_RUN: begin
                if (!sc_found) run_flag <= 1'b0;
              end
              default: ;
            endcase
          end else begin
            scan_i <= scan_i + 1'b1;
            if (sc_cand && !cand_f) begin
              cand_f <= 1'b1;
              cand_i <= scan_i;
            end
          end
        end
        tzic_pkg::S_SERVE_A: begin
          goal_q <= rd_goal;
          done_q <= rd_deliv;
          if (!zone_busy[zsel]) begin
            zone_busy       <= '0;
            zone_busy[zsel] <= 1'b1;
            flow_start      <= now_ms;
          end
        end
        tzic_pkg::S_SERVE_B: begin
          if (meter) begin
            pulse_history[0] <= flow_pulse;
          end else if (alu_ge) begin
            flow_start <= now_ms;
          end
        end
        tzic_pkg::S_CHECK: begin
          // Target reached on an earlier poll: release and look again.
          if ((goal_q != '0) && alu_ge) begin
            zone_busy[zsel] <= 1'b0;
            scan_i   <= '0;
            cand_f   <= 1'b0;
            scan_tag <= tzic_pkg::TAG_RECHECK;
          end else begin
            need_pump <= 1'b1;
          end
        end
        tzic_pkg::S_END: begin
          drive_bits <= set_drv(drive_bits, tzic_pkg::D_PUMP, need_pump,
                                fitted_mask[tzic_pkg::FIT_PUMP]);
          scan_i   <= '0;
          cand_f   <= 1'b0;
          scan_tag <= tzic_pkg::TAG_RUN;
        end
        tzic_pkg::S_OUT: begin
          if (out_free) begin
            m_tvalid       <= 1'b1;
            m_tuser        <= ok;
            m_tdata        <= '0;
            m_tdata[3:0]   <= tank_mode;
            m_tdata[5:4]   <= (tank_mode == tzic_pkg::M_FILL_FAULT) ? 2'd1 :
                              (tank_mode == tzic_pkg::M_DRAIN_FAULT) ? 2'd2 : 2'd0;
            m_tdata[6]     <= drive_bits[tzic_pkg::D_FILL];
            m_tdata[7]     <= drive_bits[tzic_pkg::D_DRAIN];
            m_tdata[8]     <= drive_bits[tzic_pkg::D_PUMP];
            m_tdata[16:9]  <= valves;
            m_tdata[20:17] <= act;
            m_tdata[44:21] <= (act == tzic_pkg::NO_ZONE) ? 24'd0 : 24'(rd_deliv);
            m_tdata[45]    <= run_flag;
            m_tdata[69:46] <= 24'(pulse_total);
            m_tdata[70]    <= freeze_flag;
          end
        end
        default: ;
      endcase
    end
  end

  // At most one zone is ever being served.
  a_one_busy: assert property (@(posedge clk) disable iff (rst) $onehot0(zone_busy))
    else $error("more than one zone busy");

  // The freeze flag only clears on reset.
  a_freeze_sticky: assert property (@(posedge clk) disable iff (rst)
    freeze_flag |=> freeze_flag)
    else $error("freeze flag dropped");

  // A fault code is only reported together with a fault state.
  a_fault_code: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[5:4] != 2'd0)) |->
      ((m_tdata[3:0] == tzic_pkg::M_FILL_FAULT) ||
       (m_tdata[3:0] == tzic_pkg::M_DRAIN_FAULT)))
    else $error("fault code without fault state");

endmodule
